>>> design/klprs_pkg.sv
// shared types and constants of the key long-press / auto-repeat scanner
// no dependencies; used by the channel interfaces, the divider and the top level
package klprs_pkg;

   localparam int unsigned TICK_W   = 32;
   localparam int unsigned SLOT_W   = 3;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_LEVEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_ENABLE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_MS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_LIMIT   = 2'd3;

   localparam logic [PERIOD_W-1:0] LONG_PRESS_MS_RESET = 16'd200;

   typedef struct packed {
      logic [TICK_W-1:0] tick_now;
      logic [SLOT_W-1:0] key_slot;
      logic              pin_level;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] event_key;
      logic              is_release;
      logic              is_long;
   } rsp_type;

   // one per-key entry of the state memory
   typedef struct packed {
      logic [TICK_W-1:0]  press_time;
      logic [COUNT_W-1:0] event_count;
   } entry_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic rem_zero;
      logic quot_nz;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

>>> design/klprs_req_if.sv
// sample channel: valid/ready handshake carrying one key sample per beat
// depends on klprs_pkg
interface klprs_req_if;
   logic              valid;
   logic              ready;
   klprs_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/klprs_rsp_if.sv
// event channel: valid/ready handshake carrying one key event per beat
// depends on klprs_pkg
interface klprs_rsp_if;
   logic              valid;
   logic              ready;
   klprs_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/key_long_press_repeat_scanner_top.sv
// Key long-press / auto-repeat scanner. Each sample beat (tick, key slot, pin level) is
// taken only while the block is idle; a sample of a held key runs the elapsed time through
// a bit-serial divider against the period in 32 one-bit steps, between the evaluate and
// finish steps; any other sample goes from evaluate to finish, and a slot at or above
// NUM_KEYS is dropped with no event. Per-key state lives in a small
// memory whose entries read as zero until first written. The event register lets the
// next sample be accepted while an earlier event still waits on the event channel.
// Depends on klprs_pkg, klprs_req_if, klprs_rsp_if and klprs_div.
module key_long_press_repeat_scanner_top #(
   parameter int unsigned NUM_KEYS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   klprs_req_if.sink                            req_chan,
   klprs_rsp_if.source                          rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [klprs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [klprs_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int unsigned IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam logic [6:0]  KEYS_LIMIT = 7'(NUM_KEYS);

   // configuration
   logic                               press_level_ff;
   logic                               burst_enable_ff;
   logic [klprs_pkg::PERIOD_W-1:0]     long_press_ms_ff;
   logic [klprs_pkg::COUNT_W-1:0]      burst_limit_ff;

   // item in flight
   klprs_pkg::state_type               state_ff, state_in;
   logic [klprs_pkg::TICK_W-1:0]       tick_ff;
   logic [klprs_pkg::SLOT_W-1:0]       slot_ff;
   logic [IDX_W-1:0]                   idx_ff;
   logic                               pressed_ff;

   // per-key state
   klprs_pkg::entry_type               mem [NUM_KEYS];
   klprs_pkg::entry_type               rd_ff;
   logic [NUM_KEYS-1:0]                valid_ff;
   klprs_pkg::entry_type               cur;
   klprs_pkg::entry_type               upd;

   // result register
   logic                               rsp_valid_ff;
   klprs_pkg::rsp_type                 rsp_ff;

   klprs_pkg::div_ctrl_type            div_ctrl;
   klprs_pkg::div_stat_type            div_stat;
   logic [klprs_pkg::TICK_W-1:0]       elapsed;

   logic                               accept;
   logic                               slot_ok;
   logic                               need_div;
   logic                               can_load;
   logic                               finish_go;
   logic                               fire;
   logic                               rel;
   logic                               period_zero;

   assign accept  = req_chan.valid && req_chan.ready;
   assign slot_ok = {4'b0, req_chan.payload.key_slot} < KEYS_LIMIT;

   // an entry never written reads as idle
   assign cur         = valid_ff[idx_ff] ? rd_ff : '0;
   assign elapsed     = tick_ff - cur.press_time;
   assign need_div    = pressed_ff && (cur.press_time != '0);
   assign can_load    = !rsp_valid_ff || rsp_chan.ready;
   assign period_zero = (long_press_ms_ff == '0);

   // event decision and entry update for the current sample
   always_comb begin
      fire = 1'b0;
      rel  = 1'b0;
      upd  = cur;
      if (pressed_ff) begin
         if (cur.press_time == '0) begin
            upd.press_time = tick_ff;
         end else if (burst_enable_ff) begin
            if ((period_zero || div_stat.rem_zero) && (cur.event_count < burst_limit_ff)) begin
               fire            = 1'b1;
               upd.event_count = cur.event_count + 1'b1;
            end
         end else if ((period_zero || div_stat.quot_nz) && (cur.event_count == '0)) begin
            fire            = 1'b1;
            upd.event_count = klprs_pkg::COUNT_W'(1);
         end
      end else if (cur.press_time != '0) begin
         fire = 1'b1;
         rel  = 1'b1;
         upd  = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         klprs_pkg::ST_IDLE: begin
            if (accept && slot_ok) state_in = klprs_pkg::ST_READ;
         end
         klprs_pkg::ST_READ:   state_in = klprs_pkg::ST_EVAL;
         klprs_pkg::ST_EVAL:   state_in = need_div ? klprs_pkg::ST_DIV : klprs_pkg::ST_FINISH;
         klprs_pkg::ST_DIV: begin
            if (div_stat.done) state_in = klprs_pkg::ST_FINISH;
         end
         klprs_pkg::ST_FINISH: begin
            if (can_load) state_in = klprs_pkg::ST_IDLE;
         end
         default:              state_in = klprs_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      div_ctrl.start = 1'b0;
      finish_go      = 1'b0;
      case (state_ff)
         klprs_pkg::ST_IDLE:   req_chan.ready = 1'b1;
         klprs_pkg::ST_EVAL:   div_ctrl.start = need_div;
         klprs_pkg::ST_FINISH: finish_go      = can_load;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= klprs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tick_ff    <= req_chan.payload.tick_now;
         slot_ff    <= req_chan.payload.key_slot;
         idx_ff     <= IDX_W'(req_chan.payload.key_slot);
         pressed_ff <= (req_chan.payload.pin_level == press_level_ff);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         press_level_ff   <= 1'b0;
         burst_enable_ff  <= 1'b0;
         long_press_ms_ff <= klprs_pkg::LONG_PRESS_MS_RESET;
         burst_limit_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            klprs_pkg::CSR_PRESS_LEVEL:   press_level_ff   <= csr_wr_data[0];
            klprs_pkg::CSR_BURST_ENABLE:  burst_enable_ff  <= csr_wr_data[0];
            klprs_pkg::CSR_LONG_PRESS_MS: long_press_ms_ff <= csr_wr_data;
            klprs_pkg::CSR_BURST_LIMIT:   burst_limit_ff   <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // per-key state memory
   always_ff @(posedge clock) begin
      if (state_ff == klprs_pkg::ST_READ) begin
         rd_ff <= mem[idx_ff];
      end
      if (finish_go) begin
         mem[idx_ff] <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (finish_go) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   // event register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go && fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go && fire) begin
         rsp_ff.event_key  <= slot_ff;
         rsp_ff.is_release <= rel;
         rsp_ff.is_long    <= !rel;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   klprs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (elapsed),
      .divisor  (long_press_ms_ff),
      .stat     (div_stat)
   );

`ifndef SYNTHESIS
   // divider is never restarted mid-run
   assert property (@(posedge clock) disable iff (reset) div_ctrl.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // divider completion only lands while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == klprs_pkg::ST_DIV))
      else $error("divider done outside wait state");

   // a new event only comes out of the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == klprs_pkg::ST_FINISH))
      else $error("event raised outside finish step");

   // a pending event is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(rsp_ff))
      else $error("pending event overwritten");

   // reset leaves every key idle
   assert property (@(posedge clock) reset |=> (valid_ff == '0))
      else $error("key state not cleared by reset");
`endif

endmodule

>>> design/klprs_div.sv
// bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one bit a cycle
// reports whether the remainder is zero and whether the quotient is nonzero; uses klprs_pkg
module klprs_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  klprs_pkg::div_ctrl_type               ctrl,
   input  logic [klprs_pkg::TICK_W-1:0]          dividend,
   input  logic [klprs_pkg::PERIOD_W-1:0]        divisor,
   output klprs_pkg::div_stat_type               stat
);

   localparam int unsigned CNT_W = $clog2(klprs_pkg::TICK_W);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [klprs_pkg::TICK_W-1:0]     num_ff, num_in;
   logic [klprs_pkg::PERIOD_W-1:0]   rem_ff, rem_in;
   logic                             qnz_ff, qnz_in;

   logic [klprs_pkg::PERIOD_W:0]     trial;
   logic [klprs_pkg::PERIOD_W:0]     diff;
   logic                             take;

   // shift the next dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, num_ff[klprs_pkg::TICK_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign take  = !diff[klprs_pkg::PERIOD_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      qnz_in  = qnz_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         qnz_in  = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[klprs_pkg::TICK_W-2:0], 1'b0};
         rem_in = take ? diff[klprs_pkg::PERIOD_W-1:0] : trial[klprs_pkg::PERIOD_W-1:0];
         qnz_in = qnz_ff | take;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(klprs_pkg::TICK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      qnz_ff <= qnz_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);
   assign stat.quot_nz  = qnz_ff;

endmodule

>>> tb/sv/klprs_event_checker.sv
`timescale 1ns / 100ps
// event checker for the key long-press scanner: follows per-key hold state from the
// sample beats and settings writes it sees, and compares every event beat in order
// depends on klprs_pkg, klprs_req_if and klprs_rsp_if
module klprs_event_checker
   import klprs_pkg::*;
#(
   parameter int unsigned NUM_KEYS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   klprs_req_if                  req_bus,
   klprs_rsp_if                  rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    fail_count,
   output int                    pending
);

   logic                press_level;
   logic                burst_on;
   logic [PERIOD_W-1:0] period;
   logic [COUNT_W-1:0]  burst_limit;

   logic [TICK_W-1:0]   hold_start   [NUM_KEYS];
   logic [TICK_W-1:0]   last_release [NUM_KEYS];
   logic [COUNT_W-1:0]  long_count   [NUM_KEYS];

   rsp_type             due_events [$];
   int                  mismatches = 0;

   task automatic scan_key_sample(input req_type s);
      logic [TICK_W-1:0] elapsed;
      logic              on_multiple;
      int unsigned       k;
      rsp_type           ev;
      k = {29'd0, s.key_slot};
      ev = '0;
      ev.event_key = s.key_slot;
      if (k >= NUM_KEYS) return;
      if (s.pin_level == press_level) begin
         last_release[k] = '0;
         // a hold stamped at tick zero still reads as idle
         if (hold_start[k] == '0) begin
            hold_start[k] = s.tick_now;
         end else begin
            elapsed = s.tick_now - hold_start[k];
            if (burst_on) begin
               on_multiple = (period == '0) || ((elapsed % {16'd0, period}) == '0);
               if (on_multiple && long_count[k] < burst_limit) begin
                  long_count[k] = long_count[k] + 1'b1;
                  ev.is_long = 1'b1;
                  due_events.push_back(ev);
               end
            end else if (elapsed >= {16'd0, period} && long_count[k] == '0) begin
               long_count[k] = COUNT_W'(1);
               ev.is_long = 1'b1;
               due_events.push_back(ev);
            end
         end
      end else if (hold_start[k] != '0) begin
         if (last_release[k] == '0) begin
            long_count[k] = '0;
            hold_start[k] = '0;
            ev.is_release = 1'b1;
            due_events.push_back(ev);
         end
         last_release[k] = s.tick_now;
      end
   endtask

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         press_level = 1'b0;
         burst_on    = 1'b0;
         period      = LONG_PRESS_MS_RESET;
         burst_limit = '0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            hold_start[i]   = '0;
            last_release[i] = '0;
            long_count[i]   = '0;
         end
         due_events.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PRESS_LEVEL:   press_level = csr_wr_data[0];
               CSR_BURST_ENABLE:  burst_on    = csr_wr_data[0];
               CSR_LONG_PRESS_MS: period      = csr_wr_data[PERIOD_W-1:0];
               CSR_BURST_LIMIT:   burst_limit = csr_wr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = rsp_bus.payload;
            if (due_events.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected event beat: key %0d release %b long %b",
                           $time, seen.event_key, seen.is_release, seen.is_long);
            end else begin
               want = due_events.pop_front();
               if (seen.event_key !== want.event_key || seen.is_release !== want.is_release ||
                   seen.is_long !== want.is_long) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: event mismatch: expected key %0d release %b long %b, %s",
                              $time, want.event_key, want.is_release, want.is_long,
                              $sformatf("got key %0d release %b long %b",
                                        seen.event_key, seen.is_release, seen.is_long));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) scan_key_sample(req_bus.payload);
      end
      pending    <= due_events.size();
      fail_count <= mismatches;
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// top of the key long-press scanner testbench: clock, reset, sample and settings stimulus
// depends on klprs_pkg, the channel interfaces, key_long_press_repeat_scanner_top and
// klprs_event_checker
module testbench;
   import klprs_pkg::*;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_PRESS_LEVEL;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  sink_ready  = 1'b0;
   bit                    steady      = 1'b0;
   int                    fail_count;
   int                    pending;

   // stimulus-side copy of the settings and of where each key's hold began
   logic                  cur_level  = 1'b0;
   logic [PERIOD_W-1:0]   cur_period = LONG_PRESS_MS_RESET;
   logic [TICK_W-1:0]     held_from [8] = '{default: '0};

   klprs_req_if req_bus();
   klprs_rsp_if rsp_bus();

   assign rsp_bus.ready = sink_ready;

   key_long_press_repeat_scanner_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   klprs_event_checker events_chk (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      sink_ready <= steady || ($urandom_range(99) >= 27);
   end

   initial begin
      #4_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   task automatic send_sample(input logic [TICK_W-1:0] tick, input logic [SLOT_W-1:0] slot,
                              input logic level);
      req_type beat;
      beat.tick_now  = tick;
      beat.key_slot  = slot;
      beat.pin_level = level;
      @(negedge clock);
      while (!steady && $urandom_range(99) < 27) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= beat;
      do @(posedge clock); while (!req_bus.ready);
      if (level == cur_level) begin
         if (held_from[slot] == '0) held_from[slot] = tick;
      end else begin
         held_from[slot] = '0;
      end
   endtask

   // upper bits of the one-bit registers carry noise, only bit 0 counts
   task automatic write_settings(input logic level, input logic burst,
                                 input logic [PERIOD_W-1:0] period,
                                 input logic [COUNT_W-1:0] limit);
      logic [CSR_DATA_W-1:0] noise;
      noise = CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PRESS_LEVEL;
      csr_wr_data <= {noise[CSR_DATA_W-1:1], level};
      @(negedge clock);
      csr_index   <= CSR_BURST_ENABLE;
      csr_wr_data <= {~noise[CSR_DATA_W-1:1], burst};
      @(negedge clock);
      csr_index   <= CSR_LONG_PRESS_MS;
      csr_wr_data <= period;
      @(negedge clock);
      csr_index   <= CSR_BURST_LIMIT;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_level  = level;
      cur_period = period;
   endtask

   // a sample that produces no event may still be in flight, so allow its latency
   task automatic drain;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (48) @(negedge clock);
   endtask

   // mostly holds sampled on multiples of the period, with stray ticks as noise
   task automatic random_sample;
      logic [SLOT_W-1:0] slot;
      logic              pressed;
      logic [TICK_W-1:0] tick;
      logic [TICK_W-1:0] span;
      int unsigned       pick;
      slot    = SLOT_W'($urandom_range(7));
      pressed = $urandom_range(99) < 78;
      pick    = $urandom_range(11);
      span    = {16'd0, cur_period};
      if (pressed && held_from[slot] != '0) begin
         if (pick < 7)       tick = held_from[slot] + span * $urandom_range(5);
         else if (pick == 7) tick = held_from[slot] + span - 1;
         else if (pick == 8) tick = held_from[slot] + span + 1;
         else if (pick == 9) tick = held_from[slot] + $urandom_range(3 * span);
         else                tick = $urandom;
      end else begin
         tick = (pick == 0) ? '0 : $urandom;
      end
      send_sample(tick, slot, pressed ? cur_level : ~cur_level);
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: pressed level 0, single long press after 200 ticks
      send_sample(32'd0, 3'd0, 1'b0);
      send_sample(32'd5, 3'd0, 1'b0);
      send_sample(32'd204, 3'd0, 1'b0);
      send_sample(32'd205, 3'd0, 1'b0);
      send_sample(32'd900, 3'd0, 1'b0);
      send_sample(32'd901, 3'd0, 1'b1);
      send_sample(32'd902, 3'd0, 1'b1);
      send_sample(32'hFFFF_FFF0, 3'd7, 1'b0);
      send_sample(32'h0000_00B8, 3'd7, 1'b0);
      send_sample(32'hFFFF_FFFF, 3'd7, 1'b1);

      // zero period in burst mode: every held sample after the first fires up to the limit
      drain();
      write_settings(1'b1, 1'b1, 16'd0, 16'd3);
      send_sample(32'd10, 3'd3, 1'b1);
      send_sample(32'd11, 3'd3, 1'b1);
      send_sample(32'd12, 3'd3, 1'b1);
      send_sample(32'd13, 3'd3, 1'b1);
      send_sample(32'd14, 3'd3, 1'b1);
      send_sample(32'd15, 3'd3, 1'b0);

      // zero period in single mode: second held sample fires at once
      drain();
      write_settings(1'b1, 1'b0, 16'd0, 16'd3);
      send_sample(32'd100, 3'd2, 1'b1);
      send_sample(32'd100, 3'd2, 1'b1);
      send_sample(32'd101, 3'd2, 1'b0);

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: write_settings(1'b1, 1'b1, 16'd5, 16'd3);
            1: write_settings(1'b0, 1'b1, 16'd1, 16'hFFFF);
            2: write_settings(1'b1, 1'b0, 16'd10, 16'd0);
            3: write_settings(1'b0, 1'b1, 16'hFFFF, 16'd4);
            4: write_settings(1'b1, 1'b1, 16'd7, 16'd0);
            7: write_settings(1'($urandom), 1'($urandom), 16'($urandom_range(1, 65535)),
                              16'($urandom_range(5)));
            default: write_settings(1'($urandom), 1'($urandom), 16'($urandom_range(1, 40)),
                                    16'($urandom_range(5)));
         endcase
         steady = (phase == 2);
         repeat (98) random_sample();
      end
      steady = 1'b0;
      drain();

      if (fail_count == 0 && pending == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
